[rtl/dotted_version_string_parser_core_macros.svh]
// Assertion macros for the version string parser.
`ifndef DOTTED_VERSION_STRING_PARSER_CORE_MACROS_SVH
`define DOTTED_VERSION_STRING_PARSER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define DVSP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dvsp: assertion failed");

// cond at one edge implies res at the next edge
`define DVSP_ASSERT_NEXT(label, clk, rst_n, cond, res) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
        else $error("dvsp: assertion failed");

`else

`define DVSP_ASSERT(label, clk, rst_n, prop)
`define DVSP_ASSERT_NEXT(label, clk, rst_n, cond, res)

`endif

`endif

[rtl/dvsp_pkg.sv]
package dvsp_pkg;

    // status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_EMPTY_NUM   = 3'd1;
    localparam logic [2:0] ST_BAD_NUM     = 3'd2;
    localparam logic [2:0] ST_END_NUM     = 3'd3;
    localparam logic [2:0] ST_EMPTY_STATE = 3'd4;
    localparam logic [2:0] ST_BAD_STATE   = 3'd5;
    localparam logic [2:0] ST_END_STATE   = 3'd6;
    localparam logic [2:0] ST_TRAILING    = 3'd7;

    // keyword codes
    localparam int         KW_COUNT        = 5;
    localparam logic [2:0] KW_EXPERIMENTAL = 3'd0;
    localparam logic [2:0] KW_BETA         = 3'd1;
    localparam logic [2:0] KW_STABLE       = 3'd2;
    localparam logic [2:0] KW_LEGACY       = 3'd3;
    localparam logic [2:0] KW_LTS          = 3'd4;

    localparam logic [3:0]  NUM_DIGITS = 4'd5;
    localparam logic [19:0] NUM_MAX    = 20'd65535;
    localparam logic [3:0]  LEN_SAT    = 4'd15;

    localparam logic [2:0] FIELD_LAST = 3'd5;

    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [8*12-1:0] TXT_EXPERIMENTAL = "experimental";
    localparam logic [8*4-1:0]  TXT_BETA         = "beta";
    localparam logic [8*6-1:0]  TXT_STABLE       = "stable";
    localparam logic [8*6-1:0]  TXT_LEGACY       = "legacy";
    localparam logic [8*3-1:0]  TXT_LTS          = "lts";

    // result fields, highest bits first in the stream word
    typedef struct packed {
        logic [2:0]  patch_kw;
        logic [2:0]  minor_kw;
        logic [2:0]  major_kw;
        logic [15:0] patch;
        logic [15:0] minor;
        logic [15:0] major;
        logic [2:0]  status;
    } dvsp_result_t;

    function automatic logic [3:0] kw_len(input logic [2:0] k);
        logic [3:0] len;
        len = 4'd0;
        unique case (k)
            KW_EXPERIMENTAL: len = 4'd12;
            KW_BETA:         len = 4'd4;
            KW_STABLE:       len = 4'd6;
            KW_LEGACY:       len = 4'd6;
            KW_LTS:          len = 4'd3;
            default:         len = 4'd0;
        endcase
        return len;
    endfunction

    // character at position pos of keyword k; zero past its end
    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [3:0] pos);
        logic [7:0] ch;
        int p;
        ch = 8'h00;
        p = int'(pos);
        unique case (k)
            KW_EXPERIMENTAL: if (p < 12) ch = TXT_EXPERIMENTAL[8*(11-p) +: 8];
            KW_BETA:         if (p < 4)  ch = TXT_BETA[8*(3-p) +: 8];
            KW_STABLE:       if (p < 6)  ch = TXT_STABLE[8*(5-p) +: 8];
            KW_LEGACY:       if (p < 6)  ch = TXT_LEGACY[8*(5-p) +: 8];
            KW_LTS:          if (p < 3)  ch = TXT_LTS[8*(2-p) +: 8];
            default:         ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

[rtl/dotted_version_string_parser_core.sv]
// Parses a zero-terminated string of the form number.state.number.state.number.state,
// one byte per request on s_axis, and emits one result on m_axis when the zero byte
// is processed. Throughput is one byte per clock while no zero byte waits on m_axis;
// a result reaches m_axis through the input register and then the result register.
// The parser state sits between those two registers, so only a zero byte waits when
// a previous result has not been taken yet. Status is the first error found; on an
// error all number and state fields of the result are zero. After a result the parser
// is back in its reset state, ready for the next string.
`include "dotted_version_string_parser_core_macros.svh"

module dotted_version_string_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] status, [18:3] major, [34:19] minor, [50:35] patch,
    // [53:51] major_kw, [56:54] minor_kw, [59:57] patch_kw, [63:60] zero
    output logic [63:0] m_axis_tdata
);

    logic       in_valid_reg;
    logic [7:0] in_char_reg;

    logic [2:0]  field_reg, field_next;
    logic [3:0]  len_reg, len_next;
    logic [15:0] acc_reg, acc_next;
    logic [2:0]  err_reg, err_next;
    logic [4:0]  cand_reg, cand_next;
    logic [15:0] held_major_reg, held_major_next;
    logic [15:0] held_minor_reg, held_minor_next;
    logic [15:0] held_patch_reg, held_patch_next;
    logic [2:0]  held_major_kw_reg, held_major_kw_next;
    logic [2:0]  held_minor_kw_reg, held_minor_kw_next;

    logic                  out_valid_reg;
    dvsp_pkg::dvsp_result_t out_data_reg, out_data_next;

    logic        is_nul, is_term, is_digit, advance;
    logic [19:0] acc_sum;
    logic [4:0]  cand_step;
    logic [2:0]  match_kw;
    logic        match_found;
    logic [2:0]  patch_kw;

    assign is_nul   = (in_char_reg == dvsp_pkg::CHAR_NUL);
    assign is_term  = is_nul || (in_char_reg == dvsp_pkg::CHAR_DOT);
    assign is_digit = (in_char_reg >= dvsp_pkg::CHAR_ZERO) &&
                      (in_char_reg <= dvsp_pkg::CHAR_NINE);

    // only a zero byte needs room in the result register
    assign advance       = in_valid_reg && (!is_nul || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // acc * 10 + digit
    assign acc_sum = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                   + {16'd0, in_char_reg[3:0]};

    always_comb
    begin
        for (int k = 0; k < dvsp_pkg::KW_COUNT; k++)
        begin
            cand_step[k] = cand_reg[k] && (len_reg < dvsp_pkg::kw_len(3'(k))) &&
                           (dvsp_pkg::kw_char(3'(k), len_reg) == in_char_reg);
        end
    end

    // lowest matching keyword wins
    always_comb
    begin
        match_kw    = 3'd0;
        match_found = 1'b0;
        for (int k = dvsp_pkg::KW_COUNT - 1; k >= 0; k--)
        begin
            if (cand_reg[k] && (len_reg == dvsp_pkg::kw_len(3'(k))))
            begin
                match_kw    = 3'(k);
                match_found = 1'b1;
            end
        end
    end

    always_comb
    begin
        field_next         = field_reg;
        len_next           = len_reg;
        acc_next           = acc_reg;
        err_next           = err_reg;
        cand_next          = cand_reg;
        held_major_next    = held_major_reg;
        held_minor_next    = held_minor_reg;
        held_patch_next    = held_patch_reg;
        held_major_kw_next = held_major_kw_reg;
        held_minor_kw_next = held_minor_kw_reg;
        patch_kw           = 3'd0;
        out_data_next      = '0;

        if (err_reg == dvsp_pkg::ST_OK)
        begin
            if (!field_reg[0])
            begin
                if (is_term)
                begin
                    if (len_reg == 4'd0)
                    begin
                        err_next = dvsp_pkg::ST_EMPTY_NUM;
                    end
                    else
                    begin
                        if (field_reg == 3'd0)
                        begin
                            held_major_next = acc_reg;
                        end
                        else if (field_reg == 3'd2)
                        begin
                            held_minor_next = acc_reg;
                        end
                        else
                        begin
                            held_patch_next = acc_reg;
                        end
                        if (is_nul)
                        begin
                            err_next = dvsp_pkg::ST_END_NUM;
                        end
                        else
                        begin
                            field_next = field_reg + 3'd1;
                            len_next   = 4'd0;
                            acc_next   = 16'd0;
                            cand_next  = '1;
                        end
                    end
                end
                else if (len_reg >= dvsp_pkg::NUM_DIGITS || !is_digit)
                begin
                    err_next = dvsp_pkg::ST_BAD_NUM;
                end
                else
                begin
                    acc_next = acc_sum[15:0];
                    if (acc_sum > dvsp_pkg::NUM_MAX)
                    begin
                        err_next = dvsp_pkg::ST_BAD_NUM;
                    end
                    len_next = len_reg + 4'd1;
                end
            end
            else
            begin
                if (is_term)
                begin
                    if (len_reg == 4'd0)
                    begin
                        err_next = dvsp_pkg::ST_EMPTY_STATE;
                    end
                    else if (!match_found)
                    begin
                        err_next = dvsp_pkg::ST_BAD_STATE;
                    end
                    else if (field_reg >= dvsp_pkg::FIELD_LAST)
                    begin
                        if (is_nul)
                        begin
                            patch_kw = match_kw;
                        end
                        else
                        begin
                            err_next = dvsp_pkg::ST_TRAILING;
                        end
                    end
                    else
                    begin
                        if (field_reg == 3'd1)
                        begin
                            held_major_kw_next = match_kw;
                        end
                        else
                        begin
                            held_minor_kw_next = match_kw;
                        end
                        if (is_nul)
                        begin
                            err_next = dvsp_pkg::ST_END_STATE;
                        end
                        else
                        begin
                            field_next = field_reg + 3'd1;
                            len_next   = 4'd0;
                            acc_next   = 16'd0;
                            cand_next  = '1;
                        end
                    end
                end
                else
                begin
                    cand_next = cand_step;
                    if (len_reg < dvsp_pkg::LEN_SAT)
                    begin
                        len_next = len_reg + 4'd1;
                    end
                end
            end
        end

        if (is_nul)
        begin
            out_data_next.status = err_next;
            if (err_next == dvsp_pkg::ST_OK)
            begin
                out_data_next.major    = held_major_next;
                out_data_next.minor    = held_minor_next;
                out_data_next.patch    = held_patch_next;
                out_data_next.major_kw = held_major_kw_next;
                out_data_next.minor_kw = held_minor_kw_next;
                out_data_next.patch_kw = patch_kw;
            end
            // back to the start of a new string
            field_next         = 3'd0;
            len_next           = 4'd0;
            acc_next           = 16'd0;
            err_next           = dvsp_pkg::ST_OK;
            cand_next          = '1;
            held_major_next    = 16'd0;
            held_minor_next    = 16'd0;
            held_patch_next    = 16'd0;
            held_major_kw_next = 3'd0;
            held_minor_kw_next = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            field_reg         <= 3'd0;
            len_reg           <= 4'd0;
            acc_reg           <= 16'd0;
            err_reg           <= dvsp_pkg::ST_OK;
            cand_reg          <= '1;
            held_major_reg    <= 16'd0;
            held_minor_reg    <= 16'd0;
            held_patch_reg    <= 16'd0;
            held_major_kw_reg <= 3'd0;
            held_minor_kw_reg <= 3'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                field_reg         <= field_next;
                len_reg           <= len_next;
                acc_reg           <= acc_next;
                err_reg           <= err_next;
                cand_reg          <= cand_next;
                held_major_reg    <= held_major_next;
                held_minor_reg    <= held_minor_next;
                held_patch_reg    <= held_patch_next;
                held_major_kw_reg <= held_major_kw_next;
                held_minor_kw_reg <= held_minor_kw_next;
            end
            if (advance && is_nul)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_char_reg <= s_axis_tdata;
        end
        if (advance && is_nul)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_data_reg};

    `DVSP_ASSERT(a_field_range, clk, rst_n, field_reg <= dvsp_pkg::FIELD_LAST)
    `DVSP_ASSERT(a_err_zero_fields, clk, rst_n,
        !out_valid_reg || out_data_reg.status == dvsp_pkg::ST_OK ||
        (out_data_reg.major == 16'd0 && out_data_reg.minor == 16'd0 &&
         out_data_reg.patch == 16'd0 && out_data_reg.patch_kw == 3'd0))
    `DVSP_ASSERT_NEXT(a_err_sticky, clk, rst_n,
        advance && !is_nul && err_reg != dvsp_pkg::ST_OK, err_reg == $past(err_reg))
    `DVSP_ASSERT_NEXT(a_restart, clk, rst_n, advance && is_nul,
        field_reg == 3'd0 && err_reg == dvsp_pkg::ST_OK && out_valid_reg)

endmodule

[verif/tb.sv]
module tb;

    localparam int          CYCLE_LIMIT    = 400000;
    localparam int          PHASE_BYTES    = 250;
    localparam logic [19:0] RADIX          = 20'd10;
    localparam logic [2:0]  FLD_MAJOR      = 3'd0;
    localparam logic [2:0]  FLD_MAJOR_KW   = 3'd1;
    localparam logic [2:0]  FLD_MINOR      = 3'd2;
    localparam logic [4:0]  ALL_KEYWORDS   = 5'h1F;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;     // [7:0] char_code
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [2:0] status, [18:3] major, [34:19] minor, [50:35] patch,
    // [53:51] major_kw, [56:54] minor_kw, [59:57] patch_kw
    logic [63:0] m_axis_tdata;

    logic [7:0]             char_stream[$];
    dvsp_pkg::dvsp_result_t expected_versions[$];
    int                     src_idle_pct = 0;
    int                     sink_stall_pct = 0;
    int                     queued_bytes = 0;
    int                     mismatches = 0;
    int                     cycles = 0;

    // parser mirror
    logic [2:0]  fld;
    logic [3:0]  flen;
    logic [19:0] acc;
    logic [2:0]  err;
    logic [4:0]  cand;
    logic [15:0] held_major, held_minor, held_patch;
    logic [2:0]  held_major_kw, held_minor_kw;

    dotted_version_string_parser_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic string kw_text(input logic [2:0] k);
        string s;
        case (k)
            dvsp_pkg::KW_EXPERIMENTAL: s = "experimental";
            dvsp_pkg::KW_BETA:         s = "beta";
            dvsp_pkg::KW_STABLE:       s = "stable";
            dvsp_pkg::KW_LEGACY:       s = "legacy";
            dvsp_pkg::KW_LTS:          s = "lts";
            default:                   s = "";
        endcase
        return s;
    endfunction

    function automatic void clear_parser();
        fld = FLD_MAJOR;
        flen = 4'd0;
        acc = 20'd0;
        err = dvsp_pkg::ST_OK;
        cand = ALL_KEYWORDS;
        held_major = 16'd0;
        held_minor = 16'd0;
        held_patch = 16'd0;
        held_major_kw = dvsp_pkg::KW_EXPERIMENTAL;
        held_minor_kw = dvsp_pkg::KW_EXPERIMENTAL;
    endfunction

    function automatic void next_field();
        fld = fld + 3'd1;
        flen = 4'd0;
        acc = 20'd0;
        cand = ALL_KEYWORDS;
    endfunction

    function automatic void parse_byte(input logic [7:0] c);
        logic                   term;
        logic                   found;
        logic [2:0]             hit;
        logic [2:0]             tail_kw;
        logic [15:0]            v;
        string                  kw;
        dvsp_pkg::dvsp_result_t r;
        term = (c == dvsp_pkg::CHAR_NUL) || (c == dvsp_pkg::CHAR_DOT);
        tail_kw = dvsp_pkg::KW_EXPERIMENTAL;
        if (err == dvsp_pkg::ST_OK)
        begin
            if (!fld[0])
            begin
                if (term)
                begin
                    if (flen == 4'd0)
                        err = dvsp_pkg::ST_EMPTY_NUM;
                    else
                    begin
                        v = acc[15:0];
                        if (fld == FLD_MAJOR)
                            held_major = v;
                        else if (fld == FLD_MINOR)
                            held_minor = v;
                        else
                            held_patch = v;
                        if (c == dvsp_pkg::CHAR_NUL)
                            err = dvsp_pkg::ST_END_NUM;
                        else
                            next_field();
                    end
                end
                else if (flen >= dvsp_pkg::NUM_DIGITS || c < dvsp_pkg::CHAR_ZERO ||
                         c > dvsp_pkg::CHAR_NINE)
                    err = dvsp_pkg::ST_BAD_NUM;
                else
                begin
                    acc = acc * RADIX + 20'(c - dvsp_pkg::CHAR_ZERO);
                    if (acc > dvsp_pkg::NUM_MAX)
                        err = dvsp_pkg::ST_BAD_NUM;
                    flen = flen + 4'd1;
                end
            end
            else
            begin
                if (term)
                begin
                    found = 1'b0;
                    hit = dvsp_pkg::KW_EXPERIMENTAL;
                    for (int k = 0; k < dvsp_pkg::KW_COUNT; k++)
                    begin
                        kw = kw_text(3'(k));
                        if (!found && cand[k] && int'(flen) == kw.len())
                        begin
                            found = 1'b1;
                            hit = 3'(k);
                        end
                    end
                    if (flen == 4'd0)
                        err = dvsp_pkg::ST_EMPTY_STATE;
                    else if (!found)
                        err = dvsp_pkg::ST_BAD_STATE;
                    else if (fld >= dvsp_pkg::FIELD_LAST)
                    begin
                        if (c == dvsp_pkg::CHAR_NUL)
                            tail_kw = hit;
                        else
                            err = dvsp_pkg::ST_TRAILING;
                    end
                    else
                    begin
                        if (fld == FLD_MAJOR_KW)
                            held_major_kw = hit;
                        else
                            held_minor_kw = hit;
                        if (c == dvsp_pkg::CHAR_NUL)
                            err = dvsp_pkg::ST_END_STATE;
                        else
                            next_field();
                    end
                end
                else
                begin
                    for (int k = 0; k < dvsp_pkg::KW_COUNT; k++)
                    begin
                        kw = kw_text(3'(k));
                        if (int'(flen) >= kw.len())
                            cand[k] = 1'b0;
                        else if (kw[flen] != c)
                            cand[k] = 1'b0;
                    end
                    if (flen < dvsp_pkg::LEN_SAT)
                        flen = flen + 4'd1;
                end
            end
        end
        if (c == dvsp_pkg::CHAR_NUL)
        begin
            r = '0;
            r.status = err;
            if (err == dvsp_pkg::ST_OK)
            begin
                r.major = held_major;
                r.minor = held_minor;
                r.patch = held_patch;
                r.major_kw = held_major_kw;
                r.minor_kw = held_minor_kw;
                r.patch_kw = tail_kw;
            end
            expected_versions.push_back(r);
            clear_parser();
        end
    endfunction

    // driver: one request per accepted byte
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= 8'h00;
            clear_parser();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                parse_byte(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (char_stream.size() > 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= char_stream.pop_front();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        dvsp_pkg::dvsp_result_t got, want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = dvsp_pkg::dvsp_result_t'(m_axis_tdata[59:0]);
                if (expected_versions.size() == 0)
                begin
                    $error("unexpected result: tdata %h", m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_versions.pop_front();
                    if (got.status != want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        mismatches++;
                    end
                    if (got.major != want.major)
                    begin
                        $error("major: expected %0d, actual %0d", want.major, got.major);
                        mismatches++;
                    end
                    if (got.minor != want.minor)
                    begin
                        $error("minor: expected %0d, actual %0d", want.minor, got.minor);
                        mismatches++;
                    end
                    if (got.patch != want.patch)
                    begin
                        $error("patch: expected %0d, actual %0d", want.patch, got.patch);
                        mismatches++;
                    end
                    if (got.major_kw != want.major_kw)
                    begin
                        $error("major_kw: expected %0d, actual %0d",
                               want.major_kw, got.major_kw);
                        mismatches++;
                    end
                    if (got.minor_kw != want.minor_kw)
                    begin
                        $error("minor_kw: expected %0d, actual %0d",
                               want.minor_kw, got.minor_kw);
                        mismatches++;
                    end
                    if (got.patch_kw != want.patch_kw)
                    begin
                        $error("patch_kw: expected %0d, actual %0d",
                               want.patch_kw, got.patch_kw);
                        mismatches++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        char_stream.push_back(b);
        queued_bytes++;
    endtask

    // text plus terminating zero byte
    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
        push_byte(dvsp_pkg::CHAR_NUL);
    endtask

    function automatic string rand_number();
        string s;
        int    d;
        if ($urandom_range(99) < 25)
        begin
            case ($urandom_range(7))
                0: s = "0";
                1: s = "65535";
                2: s = "65536";
                3: s = "99999";
                4: s = "00001";
                5: s = "65529";
                6: s = "123456";
                default: s = "6553";
            endcase
        end
        else
        begin
            d = $urandom_range(1, 5);
            s = "";
            for (int i = 0; i < d; i++)
                s = {s, $sformatf("%0d", $urandom_range(9))};
        end
        return s;
    endfunction

    task automatic queue_random_string();
        int         kind;
        int         n;
        int         p;
        string      s;
        logic [7:0] txt[$];
        kind = $urandom_range(99);
        if (kind < 12)
        begin
            n = $urandom_range(1, 24);
            repeat (n) push_byte(8'($urandom_range(1, 255)));
            push_byte(dvsp_pkg::CHAR_NUL);
        end
        else
        begin
            s = "";
            for (int f = 0; f < 6; f++)
            begin
                if (f > 0)
                    s = {s, "."};
                if (f % 2 == 0)
                    s = {s, rand_number()};
                else
                    s = {s, kw_text(3'($urandom_range(0, dvsp_pkg::KW_COUNT - 1)))};
            end
            for (int i = 0; i < s.len(); i++)
                txt.push_back(s[i]);
            if (kind >= 68)
            begin
                p = $urandom_range(0, txt.size() - 1);
                case ($urandom_range(5))
                    0: while (txt.size() > p) txt.pop_back();
                    1: txt[p] = 8'($urandom_range(0, 255));
                    2: txt.delete(p);
                    3: txt.insert(p, dvsp_pkg::CHAR_DOT);
                    4:
                    begin
                        txt.push_back(dvsp_pkg::CHAR_DOT);
                        if ($urandom_range(1))
                            txt.push_back(8'($urandom_range(1, 255)));
                    end
                    default: txt[p] = 8'($urandom_range(1, 255)) | 8'h80;
                endcase
            end
            foreach (txt[i])
                push_byte(txt[i]);
            push_byte(dvsp_pkg::CHAR_NUL);
        end
    endtask

    task automatic drain();
        while (char_stream.size() > 0 || s_axis_tvalid || expected_versions.size() > 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int idle, input int stall);
        int start;
        @(negedge clk);
        src_idle_pct = idle;
        sink_stall_pct = stall;
        start = queued_bytes;
        while (queued_bytes - start < PHASE_BYTES)
            queue_random_string();
        drain();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        push_text("1.beta.2.stable.3.lts");
        push_text("65535.experimental.65535.legacy.65535.experimental");
        push_text("0.lts.0.lts.0.lts");
        push_text("00042.stable.00.beta.1.experimental");
        push_text("");
        push_text(".beta");
        push_text("123456.beta");
        push_text("65536.beta");
        push_text("12a.beta");
        push_text("x\377\200.beta.\001");
        push_text("7");
        push_text("7.");
        push_text("7..beta");
        push_text("7.betas.1.lts.1.lts");
        push_text("7.bet.1.lts.1.lts");
        push_text("7.lt");
        push_text("7.experimentalexperimental.1.lts.1.lts");
        push_text("7.stable");
        push_text("7.legacy.8");
        push_text("7.legacy.8.");
        push_text("7.legacy.8.lts");
        push_text("7.legacy.8.lts.9");
        push_text("7.legacy.8.lts.9.STABLE");
        push_text("7.legacy.8.lts.9.beta.");
        push_text("7.legacy.8.lts.9.beta.junk");
        drain();

        run_phase(0, 0);
        run_phase(68, 0);
        run_phase(0, 68);
        run_phase(28, 28);

        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_versions.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

[files.f]
+incdir+rtl
rtl/dvsp_pkg.sv
rtl/dotted_version_string_parser_core.sv
verif/tb.sv
